// ----- rtl/core/jkc_pkg.sv -----
package jkc_pkg;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_step;
    logic ins;
    logic compact_start;
    logic wb_step;
    logic append;
    logic clear;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    kind_e kind;
    logic  need_compact;
    logic  scan_last;
    logic  list_empty;
    logic  wb_last;
    logic  out_free;
  } sts_t;

endpackage

// ----- rtl/core/jkc_ctrl.sv -----
module jkc_ctrl
  import jkc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output logic in_stall_o,
  output cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DISP = 8'b0000_0010,
    S_RD   = 8'b0000_0100,
    S_INS  = 8'b0000_1000,
    S_CMP  = 8'b0001_0000,
    S_WB   = 8'b0010_0000,
    S_APP  = 8'b0100_0000,
    S_RES  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.kind)
          KIND_APPEND: begin
            if (sts_i.need_compact) begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_RD;
            end else begin
              state_d = S_APP;
            end
          end
          KIND_READ: begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_RD;
          end
          KIND_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d     = S_RES;
          end
          default: state_d = S_RES;
        endcase
      end
      S_RD: state_d = S_INS;
      S_INS: begin
        cmd_o.ins = 1'b1;
        if (!sts_i.scan_last) begin
          cmd_o.scan_step = 1'b1;
          state_d         = S_RD;
        end else if (sts_i.kind == KIND_APPEND) begin
          state_d = S_CMP;
        end else begin
          state_d = S_RES;
        end
      end
      S_CMP: begin
        cmd_o.compact_start = 1'b1;
        state_d             = sts_i.list_empty ? S_APP : S_WB;
      end
      S_WB: begin
        cmd_o.wb_step = 1'b1;
        if (sts_i.wb_last) begin
          state_d = S_APP;
        end
      end
      S_APP: begin
        cmd_o.append = 1'b1;
        state_d      = S_RES;
      end
      S_RES: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/jkc_dp.sv -----
module jkc_dp
  import jkc_pkg::*;
#(
  parameter int JOURNAL_SLOTS = 16,
  parameter int KEEP_SLOTS    = 8,
  parameter int MAX_LENGTH    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] rec_length_i,
  input  logic [31:0] rec_payload_i,
  input  logic [7:0]  newest_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [31:0] seq_out_o,
  output logic [6:0]  length_out_o,
  output logic [31:0] payload_out_o,
  output logic [3:0]  count_out_o
);

  localparam int KE  = (KEEP_SLOTS < JOURNAL_SLOTS) ? KEEP_SLOTS : JOURNAL_SLOTS;
  localparam int SW  = $clog2(JOURNAL_SLOTS);
  localparam int NW  = $clog2(JOURNAL_SLOTS + 1);
  localparam int NLW = $clog2(KE + 1);
  localparam int LIW = (KE > 1) ? $clog2(KE) : 1;
  localparam int CW  = $clog2(KEEP_SLOTS + 1);
  localparam int LW  = $clog2(MAX_LENGTH + 1);

  // Latched item
  kind_e          kind_q;
  logic [LW-1:0]  len_q;
  logic [31:0]    pay_q;
  logic [7:0]     off_q;

  // Journal state
  logic [JOURNAL_SLOTS-1:0] vld_q;
  logic [NW-1:0]  next_slot_q;
  logic [CW-1:0]  vt_q;
  logic [31:0]    seq_ctr_q;
  logic [SW-1:0]  scan_q;
  logic [SW-1:0]  wb_q;
  logic [NLW-1:0] n_q;

  // Slot store
  logic [31:0]    mem_seq [JOURNAL_SLOTS];
  logic [LW-1:0]  mem_len [JOURNAL_SLOTS];
  logic [31:0]    mem_pay [JOURNAL_SLOTS];
  logic [31:0]    rd_seq_q;
  logic [LW-1:0]  rd_len_q;
  logic [31:0]    rd_pay_q;
  logic           rd_vld_q;

  // Sorted newest list, newest at cell 0
  logic [31:0]    c_seq [KE];
  logic [LW-1:0]  c_len [KE];
  logic [31:0]    c_pay [KE];
  logic [31:0]    pv_seq [KE];
  logic [LW-1:0]  pv_len [KE];
  logic [31:0]    pv_pay [KE];
  logic [31:0]    nx_seq [KE];
  logic [LW-1:0]  nx_len [KE];
  logic [31:0]    nx_pay [KE];
  logic [KE-1:0]  ge;
  logic [KE-1:0]  ge_prev;

  logic           out_valid_q;
  logic           found_q;
  logic [31:0]    seq_out_q;
  logic [6:0]     len_out_q;
  logic [31:0]    pay_out_q;
  logic [3:0]     cnt_out_q;

  logic [LW-1:0]  clamp;
  logic [SW-1:0]  wb_addr;
  logic           wb_last;
  logic           app_room;
  logic           we;
  logic [SW-1:0]  waddr;
  logic [31:0]    wseq;
  logic [LW-1:0]  wlen;
  logic [31:0]    wpay;
  logic           hit;
  logic [LIW+7:0] offx;
  logic [LIW-1:0] ridx;
  logic [LW+6:0]  lenx;
  logic [CW+3:0]  cntx;
  logic [31:0]    wb_sum;

  assign clamp = (rec_length_i > 16'(MAX_LENGTH)) ? LW'(MAX_LENGTH) : rec_length_i[LW-1:0];

  assign wb_sum   = 32'(n_q) - 32'd1 - 32'(wb_q);
  assign wb_addr  = wb_sum[SW-1:0];
  assign wb_last  = (32'(wb_q) == (32'(n_q) - 32'd1));
  assign app_room = (next_slot_q != NW'(JOURNAL_SLOTS));

  assign sts_o.kind         = kind_q;
  assign sts_o.need_compact = ~app_room;
  assign sts_o.scan_last    = (scan_q == SW'(JOURNAL_SLOTS - 1));
  assign sts_o.list_empty   = (n_q == '0);
  assign sts_o.wb_last      = wb_last;
  assign sts_o.out_free     = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_e'(kind_i);
      len_q  <= clamp;
      pay_q  <= rec_payload_i;
      off_q  <= newest_offset_i;
    end
  end

  // Store write: write back from the list head, or append the new record
  assign we    = cmd_i.wb_step | (cmd_i.append & app_room);
  assign waddr = cmd_i.wb_step ? wb_addr : next_slot_q[SW-1:0];
  assign wseq  = cmd_i.wb_step ? c_seq[0] : seq_ctr_q + 32'd1;
  assign wlen  = cmd_i.wb_step ? c_len[0] : len_q;
  assign wpay  = cmd_i.wb_step ? c_pay[0] : pay_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_seq[waddr] <= wseq;
      mem_len[waddr] <= wlen;
      mem_pay[waddr] <= wpay;
    end
    rd_seq_q <= mem_seq[scan_q];
    rd_len_q <= mem_len[scan_q];
    rd_pay_q <= mem_pay[scan_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      next_slot_q <= '0;
      vt_q        <= '0;
      seq_ctr_q   <= '0;
      scan_q      <= '0;
      wb_q        <= '0;
      n_q         <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[scan_q];
      if (cmd_i.scan_start) begin
        scan_q <= '0;
        n_q    <= '0;
      end
      if (cmd_i.scan_step) begin
        scan_q <= scan_q + SW'(1);
      end
      if (cmd_i.ins && rd_vld_q && (n_q != NLW'(KE))) begin
        n_q <= n_q + NLW'(1);
      end
      if (cmd_i.clear) begin
        vld_q       <= '0;
        next_slot_q <= '0;
        vt_q        <= '0;
        seq_ctr_q   <= '0;
      end
      if (cmd_i.compact_start) begin
        vld_q       <= '0;
        next_slot_q <= NW'(n_q);
        vt_q        <= CW'(n_q);
        wb_q        <= '0;
      end
      if (cmd_i.wb_step) begin
        vld_q[wb_addr] <= 1'b1;
        wb_q           <= wb_q + SW'(1);
      end
      if (cmd_i.append) begin
        seq_ctr_q <= seq_ctr_q + 32'd1;
        if (app_room) begin
          vld_q[next_slot_q[SW-1:0]] <= 1'b1;
          next_slot_q                <= next_slot_q + NW'(1);
        end
        if (vt_q != CW'(KEEP_SLOTS)) begin
          vt_q <= vt_q + CW'(1);
        end
      end
    end
  end

  // Neighbor views of the list
  for (genvar g = 0; g < KE; g++) begin : g_nb
    assign ge[g] = (c_seq[g] >= rd_seq_q);
    if (g == 0) begin : g_first
      assign ge_prev[g] = 1'b1;
      assign pv_seq[g]  = c_seq[g];
      assign pv_len[g]  = c_len[g];
      assign pv_pay[g]  = c_pay[g];
    end else begin : g_rest
      assign ge_prev[g] = ge[g-1];
      assign pv_seq[g]  = c_seq[g-1];
      assign pv_len[g]  = c_len[g-1];
      assign pv_pay[g]  = c_pay[g-1];
    end
    if (g == KE - 1) begin : g_last
      assign nx_seq[g] = c_seq[g];
      assign nx_len[g] = c_len[g];
      assign nx_pay[g] = c_pay[g];
    end else begin : g_mid
      assign nx_seq[g] = c_seq[g+1];
      assign nx_len[g] = c_len[g+1];
      assign nx_pay[g] = c_pay[g+1];
    end
  end

  // Insert below every entry at least as new; pop the head on write-back
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < KE; i++) begin
      if (cmd_i.ins && rd_vld_q && (32'(i) <= 32'(n_q))) begin
        if ((32'(i) < 32'(n_q)) && ge[i]) begin
          c_seq[i] <= c_seq[i];
        end else if (ge_prev[i]) begin
          c_seq[i] <= rd_seq_q;
          c_len[i] <= rd_len_q;
          c_pay[i] <= rd_pay_q;
        end else begin
          c_seq[i] <= pv_seq[i];
          c_len[i] <= pv_len[i];
          c_pay[i] <= pv_pay[i];
        end
      end else if (cmd_i.wb_step) begin
        c_seq[i] <= nx_seq[i];
        c_len[i] <= nx_len[i];
        c_pay[i] <= nx_pay[i];
      end
    end
  end

  assign hit  = (32'(off_q) < 32'(n_q));
  assign offx = {{LIW{1'b0}}, off_q};
  assign ridx = offx[LIW-1:0];
  assign cntx = {4'b0, vt_q};

  always_comb begin
    lenx = '0;
    unique case (kind_q)
      KIND_APPEND: lenx = {7'b0, len_q};
      KIND_READ:   lenx = hit ? {7'b0, c_len[ridx]} : '0;
      default:     lenx = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      len_out_q <= lenx[6:0];
      cnt_out_q <= cntx[3:0];
      unique case (kind_q)
        KIND_APPEND: begin
          found_q   <= 1'b1;
          seq_out_q <= seq_ctr_q;
          pay_out_q <= '0;
        end
        KIND_CLEAR: begin
          found_q   <= 1'b1;
          seq_out_q <= '0;
          pay_out_q <= '0;
        end
        KIND_READ: begin
          found_q   <= hit;
          seq_out_q <= hit ? c_seq[ridx] : '0;
          pay_out_q <= hit ? c_pay[ridx] : '0;
        end
        default: begin
          found_q   <= 1'b0;
          seq_out_q <= '0;
          pay_out_q <= '0;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign seq_out_o     = seq_out_q;
  assign length_out_o  = len_out_q;
  assign payload_out_o = pay_out_q;
  assign count_out_o   = cnt_out_q;

endmodule

// ----- rtl/core/journal_keep_newest_compactor.sv -----
// Append-only journal of sequence-numbered records with keep-newest compaction.
// Input channel (in_valid_i / in_stall_o) carries one command item: append,
// clear, or read the offset-th newest record. Output channel (out_valid_o /
// out_stall_i) returns exactly one result item per command, in order.
// An item is taken when valid is high and stall is low at a rising edge.
// Steps per kind, J = JOURNAL_SLOTS:
//   clear, unused kind        : dispatch, then the output register
//   append, store not full    : dispatch, append, output register
//   read by offset            : scan of all J slots (one store read per slot,
//                               each valid record sorted into the list)
//   append with compaction    : scan, one write-back per kept record over
//                               the single write port, then the append
// One item is in work at a time; the next is taken once the result is handed
// to the output register, which may still be waiting on the receiver.
// A stalled result holds its fields; a finished item waits until the output
// register frees up, and the input stays stalled meanwhile.
// Reset clears the valid bits, counters and sequence at once; store contents
// need no clearing pass since only valid slots are ever used.
module journal_keep_newest_compactor
  import jkc_pkg::*;
#(
  parameter int JOURNAL_SLOTS = 16,
  parameter int KEEP_SLOTS    = 8,
  parameter int MAX_LENGTH    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] rec_length_i,
  input  logic [31:0] rec_payload_i,
  input  logic [7:0]  newest_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [31:0] seq_out_o,
  output logic [6:0]  length_out_o,
  output logic [31:0] payload_out_o,
  output logic [3:0]  count_out_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequence the command: dispatch, scan, compact, write back, append, answer
  jkc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // Hold the store, the counters, the sorted newest list and the result
  jkc_dp #(
    .JOURNAL_SLOTS (JOURNAL_SLOTS),
    .KEEP_SLOTS    (KEEP_SLOTS),
    .MAX_LENGTH    (MAX_LENGTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (kind_i),
    .rec_length_i    (rec_length_i),
    .rec_payload_i   (rec_payload_i),
    .newest_offset_i (newest_offset_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_o         (found_o),
    .seq_out_o       (seq_out_o),
    .length_out_o    (length_out_o),
    .payload_out_o   (payload_out_o),
    .count_out_o     (count_out_o)
  );

endmodule
